// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define XS_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// clocked assertion, also checked during reset
`define XS_ASSERT_RST(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("assertion failed during reset");

`endif

// ===== rtl/xs128_pkg.sv =====
// ----------------------------------------------------------------------------
// xs128_pkg
// types and constants of the xorshift128+ bounded generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xs128_pkg;

	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE = 8'd1;

	localparam logic [63:0] SEED_XOR_K = 64'hDEADBEEFCAFEBABE;
	localparam logic [63:0] SEED_MUL_K = 64'h2545F4914F6CDD1D;
	localparam logic [63:0] SEED_ADD_K = 64'h0123456789ABCDEF;
	localparam logic [63:0] SEED_RESET = 64'h00000100000001B3;
	localparam logic [31:0] RANGE_RESET = 32'd10000;

	localparam int unsigned SH_A = 23;
	localparam int unsigned SH_B = 17;
	localparam int unsigned SH_C = 26;

	function automatic logic [63:0] fix_first(input logic [63:0] first,
		input logic [63:0] second);
		if (first == 64'd0 && second == 64'd0) begin
			return 64'd1;
		end
		return first;
	endfunction

	localparam logic [63:0] RESET_SECOND_RAW = SEED_RESET * SEED_MUL_K;
	localparam logic [63:0] RESET_SECOND = RESET_SECOND_RAW ^ SEED_ADD_K;
	localparam logic [63:0] RESET_FIRST = fix_first(SEED_RESET ^ SEED_XOR_K, RESET_SECOND);

	typedef enum logic [1:0] {
		MUL_LO_LO = 2'd0,
		MUL_HI_LO = 2'd1,
		MUL_LO_HI = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_load;
		logic     acc_add;
		logic     words_load;
		logic     step;
		logic     div_iter;
		logic     out_load;
	} xs_cmd_t;

	typedef struct packed {
		logic seed_wr;
		logic div_last;
	} xs_sts_t;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_SEED_A   = 9'b000000010,
		ST_SEED_B   = 9'b000000100,
		ST_SEED_C   = 9'b000001000,
		ST_SEED_D   = 9'b000010000,
		ST_SEED_FIN = 9'b000100000,
		ST_STEP     = 9'b001000000,
		ST_DIV      = 9'b010000000,
		ST_DONE     = 9'b100000000
	} state_t;

endpackage

// ===== rtl/xs128_if.sv =====
// ----------------------------------------------------------------------------
// xs128_if
// request and result channels of the generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface xs128_req_if;
	logic valid;
	logic ready;
	logic draw_request;

	modport source (output valid, output draw_request, input ready);
	modport sink (input valid, input draw_request, output ready);
endinterface

interface xs128_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] raw_number;
	logic [31:0] bounded_number;

	modport source (output valid, output raw_number, output bounded_number, input ready);
	modport sink (input valid, input raw_number, input bounded_number, output ready);
endinterface

// ===== rtl/xs128_datapath.sv =====
// ----------------------------------------------------------------------------
// xs128_datapath
// config registers, state words, seed multiplier, divider and result regs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xs128_datapath
	import xs128_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_wdata,
	input  xs_cmd_t              cmd,
	output xs_sts_t              sts,
	output logic [63:0]          raw_number,
	output logic [31:0]          bounded_number
);

	logic [63:0] seed_q;
	logic [31:0] range_q;
	logic [63:0] first_q;
	logic [63:0] second_q;
	logic [63:0] mul_q;
	logic [63:0] acc_q;
	logic [63:0] sum_q;
	logic [63:0] div_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic [63:0] raw_q;
	logic [31:0] bnd_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] xa;
	logic [63:0] xb;
	logic [63:0] xn;
	logic [63:0] new_second;
	logic [32:0] rem_sh;
	logic [32:0] rem_diff;
	logic        seed_wr;
	logic        range_wr;

	assign seed_wr  = cfg_we && (cfg_index == CFG_SEED);
	assign range_wr = cfg_we && (cfg_index == CFG_RANGE);

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_LO_LO: begin
				mul_a = seed_q[31:0];
				mul_b = SEED_MUL_K[31:0];
			end
			MUL_HI_LO: begin
				mul_a = seed_q[63:32];
				mul_b = SEED_MUL_K[31:0];
			end
			MUL_LO_HI: begin
				mul_a = seed_q[31:0];
				mul_b = SEED_MUL_K[63:32];
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	assign mul_p      = {32'd0, mul_a} * {32'd0, mul_b};
	assign new_second = acc_q ^ SEED_ADD_K;

	assign xa = first_q ^ (first_q << SH_A);
	assign xb = xa ^ (xa >> SH_B);
	assign xn = xb ^ second_q ^ (second_q >> SH_C);

	assign rem_sh   = {rem_q, div_q[63]};
	assign rem_diff = rem_sh - {1'b0, range_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= SEED_RESET;
			range_q  <= RANGE_RESET;
			first_q  <= RESET_FIRST;
			second_q <= RESET_SECOND;
		end else begin
			if (seed_wr) begin
				seed_q <= cfg_wdata;
			end
			if (range_wr) begin
				range_q <= (cfg_wdata[31:0] == 32'd0) ? 32'd1 : cfg_wdata[31:0];
			end
			if (cmd.words_load) begin
				first_q  <= fix_first(seed_q ^ SEED_XOR_K, new_second);
				second_q <= new_second;
			end else if (cmd.step) begin
				first_q  <= second_q;
				second_q <= xn;
			end
		end
	end

	// seed product mod 2^64 from three 32x32 partial products
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			mul_q <= mul_p;
		end
		if (cmd.acc_load) begin
			acc_q <= mul_q;
		end else if (cmd.acc_add) begin
			acc_q[63:32] <= acc_q[63:32] + mul_q[31:0];
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			sum_q <= xn + second_q;
			div_q <= xn + second_q;
			rem_q <= 32'd0;
			cnt_q <= 6'd0;
		end else if (cmd.div_iter) begin
			div_q <= {div_q[62:0], 1'b0};
			rem_q <= rem_diff[32] ? rem_sh[31:0] : rem_diff[31:0];
			cnt_q <= cnt_q + 6'd1;
		end
		if (cmd.out_load) begin
			raw_q <= sum_q;
			bnd_q <= rem_q;
		end
	end

	assign sts.seed_wr  = seed_wr;
	assign sts.div_last = (cnt_q == 6'd63);

	assign raw_number     = raw_q;
	assign bounded_number = bnd_q;

endmodule

// ===== rtl/xs128_ctrl.sv =====
// ----------------------------------------------------------------------------
// xs128_ctrl
// sequencer for seeding, state step, division and result handoff
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xs128_ctrl
	import xs128_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  logic    req_draw,
	output logic    req_ready,
	output logic    res_valid,
	input  logic    res_ready,
	input  xs_sts_t sts,
	output xs_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || res_ready;

	always_comb begin
		cmd       = '0;
		cmd.mul_sel = MUL_LO_LO;
		req_ready = 1'b0;
		state_d   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = !sts.seed_wr;
				if (req_valid && req_draw) begin
					state_d = ST_STEP;
				end
			end
			ST_SEED_A: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_SEED_B;
			end
			ST_SEED_B: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_HI_LO;
				cmd.acc_load = 1'b1;
				state_d      = ST_SEED_C;
			end
			ST_SEED_C: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_LO_HI;
				cmd.acc_add = 1'b1;
				state_d     = ST_SEED_D;
			end
			ST_SEED_D: begin
				cmd.acc_add = 1'b1;
				state_d     = ST_SEED_FIN;
			end
			ST_SEED_FIN: begin
				cmd.words_load = 1'b1;
				state_d        = ST_IDLE;
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_iter = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					req_ready    = !sts.seed_wr;
					state_d      = (req_valid && req_draw) ? ST_STEP : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (sts.seed_wr) begin
			state_d = ST_SEED_A;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;

endmodule

// ===== rtl/xorshift128plus_bounded_generator_top.sv =====
// ----------------------------------------------------------------------------
// xorshift128plus_bounded_generator_top: draw beat to result beat via STEP, DIV, DONE
// one draw at a time, paced by the 64-step restoring divider (one bit/cycle)
// seed write blocks requests in its own cycle and in SEED_A to SEED_FIN (shared multiplier)
// reset loads both state words from the reset seed at once, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xorshift128plus_bounded_generator_top
	import xs128_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	xs128_req_if.sink            req,
	xs128_res_if.source          res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_wdata
);

	xs_cmd_t cmd;
	xs_sts_t sts;

	xs128_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_draw  (req.draw_request),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	xs128_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.cmd            (cmd),
		.sts            (sts),
		.raw_number     (res.raw_number),
		.bounded_number (res.bounded_number)
	);

endmodule

// ===== rtl/xs128_checker.sv =====
// ----------------------------------------------------------------------------
// xs128_checker
// port-level checks of the generator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xs128_checker
	import xs128_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 req_draw,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic [63:0]          raw_number,
	input logic [31:0]          bounded_number,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index
);

	`XS_ASSERT_RST(a_no_result_in_reset, clk, !arst_n |-> !res_valid)
	`XS_ASSERT(a_result_holds, clk, arst_n, res_valid && !res_ready |=> res_valid && $stable(raw_number) && $stable(bounded_number))
	`XS_ASSERT(a_bounded_not_above_raw, clk, arst_n, res_valid |-> raw_number >= 64'(bounded_number))
	`XS_ASSERT(a_busy_after_draw, clk, arst_n, req_valid && req_ready && req_draw |=> !req_ready)
	`XS_ASSERT(a_busy_after_seed, clk, arst_n, cfg_we && cfg_index == CFG_SEED |=> !req_ready)

endmodule

bind xorshift128plus_bounded_generator_top xs128_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_draw       (req.draw_request),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.raw_number     (res.raw_number),
	.bounded_number (res.bounded_number),
	.cfg_we         (cfg_we),
	.cfg_index      (cfg_index)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// testbench of the xorshift128+ bounded generator: a queue-fed request driver
// and a result monitor check every result beat against a built-in model of
// the state words, over several seed and range settings with random stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import xs128_pkg::*;

	localparam int unsigned DRAIN_CYCLES = 80;
	localparam int unsigned MAX_GAP = 19;
	localparam int unsigned DRAW_TARGET = 720;

	typedef struct {
		bit          draw;
		int unsigned gap;
	} request_t;

	typedef struct {
		logic [63:0] raw;
		logic [31:0] bounded;
	} number_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_wdata;

	xs128_req_if req();
	xs128_res_if res();

	xorshift128plus_bounded_generator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// model state
	logic [63:0] gen_first;
	logic [63:0] gen_second;
	logic [31:0] gen_range;

	request_t    draw_queue[$];
	number_t     predicted_numbers[$];
	int unsigned draws_queued = 0;
	int unsigned mismatches = 0;

	int          req_beats = 0;
	int          req_sent = 0;
	bit          have_next = 1'b0;
	request_t    next_req;
	int unsigned gap_left = 0;

	int          res_beats = 0;
	int          res_seen = 0;
	int unsigned ready_hold = 0;
	bit          ready_quiet = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void reload_words(input logic [63:0] seed);
		gen_first = seed ^ SEED_XOR_K;
		gen_second = (seed * SEED_MUL_K) ^ SEED_ADD_K;
		if (gen_first == 64'd0 && gen_second == 64'd0) begin
			gen_first = 64'd1;
		end
	endfunction

	function automatic number_t next_number();
		logic [63:0] x;
		logic [63:0] y;
		number_t     n;
		x = gen_first;
		y = gen_second;
		x = x ^ (x << SH_A);
		x = x ^ (x >> SH_B);
		x = x ^ y ^ (y >> SH_C);
		gen_first = y;
		gen_second = x;
		n.raw = x + y;
		n.bounded = 32'(n.raw % {32'd0, gen_range});
		return n;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatches++;
		$display("%0t ns: %s: got %h, want %h", $time, what, got, want);
	endtask

	// result check first, then prediction of the request beat
	always @(posedge clk) begin
		number_t want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				res_beats <= res_beats + 1;
				if (predicted_numbers.size() == 0) begin
					report_mismatch("result beat with no draw pending", res.raw_number, 64'd0);
				end else begin
					want = predicted_numbers.pop_front();
					if (res.raw_number !== want.raw) begin
						report_mismatch("raw_number", res.raw_number, want.raw);
					end
					if (res.bounded_number !== want.bounded) begin
						report_mismatch("bounded_number", {32'd0, res.bounded_number},
							{32'd0, want.bounded});
					end
				end
			end
			if (req.valid && req.ready) begin
				req_beats <= req_beats + 1;
				if (req.draw_request) begin
					predicted_numbers = {predicted_numbers, next_number()};
				end
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (req.valid && req_beats != req_sent) begin
			end else if (have_next) begin
				if (gap_left > 0) begin
					req.valid <= 1'b0;
					gap_left--;
				end else begin
					req.valid <= 1'b1;
					req.draw_request <= next_req.draw;
					req_sent++;
					have_next = 1'b0;
				end
			end else if (draw_queue.size() > 0) begin
				next_req = draw_queue.pop_front();
				if (next_req.gap == 0) begin
					req.valid <= 1'b1;
					req.draw_request <= next_req.draw;
					req_sent++;
				end else begin
					req.valid <= 1'b0;
					gap_left = next_req.gap - 1;
					have_next = 1'b1;
				end
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// result stalls, drawn once per result beat
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_beats != res_seen) begin
				res_seen = res_beats;
				if (res_seen % 40 == 0) begin
					ready_quiet = ($urandom_range(0, 3) == 0);
				end
				ready_hold = ready_quiet ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (ready_hold > 0) begin
				res.ready <= 1'b0;
				ready_hold--;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	task automatic queue_draws(input int unsigned count, input int unsigned noise_pct,
		input bit calm);
		request_t r;
		for (int i = 0; i < count; i++) begin
			r.draw = ($urandom_range(0, 99) >= noise_pct);
			r.gap = calm ? 0 : $urandom_range(0, MAX_GAP);
			if (r.draw) begin
				draws_queued++;
			end
			draw_queue = {draw_queue, r};
		end
	endtask

	task automatic wait_drained();
		while (!(draw_queue.size() == 0 && !have_next && req_beats == req_sent &&
			predicted_numbers.size() == 0)) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SEED) begin
			reload_words(data);
		end else if (idx == CFG_RANGE) begin
			gen_range = (data[31:0] == 32'd0) ? 32'd1 : data[31:0];
		end
	endtask

	initial begin
		logic [31:0] range_pick;
		request_t    idle_req;
		arst_n <= 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.draw_request = 1'b0;
		res.ready = 1'b0;
		gen_range = RANGE_RESET;
		reload_words(SEED_RESET);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset seed and range, with one idle request beat
		queue_draws(3, 0, 1'b1);
		idle_req.draw = 1'b0;
		idle_req.gap = 2;
		draw_queue = {draw_queue, idle_req};
		queue_draws(1, 0, 1'b0);
		wait_drained();

		// zero range saturates to one
		cfg_write(CFG_RANGE, 64'd0);
		queue_draws(2, 0, 1'b0);
		wait_drained();
		cfg_write(CFG_RANGE, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_draws(3, 0, 1'b1);
		wait_drained();
		cfg_write(CFG_RANGE, 64'd2);
		queue_draws(2, 0, 1'b0);
		wait_drained();
		cfg_write(CFG_RANGE, 64'hFFFF_FFFF_0000_0000);
		queue_draws(1, 0, 1'b0);
		wait_drained();

		// seed extremes, and the seed that clears the first word
		cfg_write(CFG_RANGE, 64'd1);
		cfg_write(CFG_SEED, 64'd0);
		queue_draws(2, 0, 1'b1);
		wait_drained();
		cfg_write(CFG_RANGE, 64'd10000);
		cfg_write(CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_draws(2, 0, 1'b0);
		wait_drained();
		cfg_write(CFG_SEED, SEED_XOR_K);
		queue_draws(2, 0, 1'b0);
		wait_drained();

		// writes to unknown indexes change nothing
		cfg_write(8'd2, {$urandom, $urandom});
		cfg_write(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_draws(2, 0, 1'b0);
		wait_drained();

		while (draws_queued < DRAW_TARGET) begin
			case ($urandom_range(0, 5))
				0: range_pick = $urandom_range(1, 16);
				1: range_pick = $urandom;
				2: range_pick = 32'd1 << $urandom_range(0, 31);
				3: range_pick = 32'hFFFF_FFFF - $urandom_range(0, 3);
				4: range_pick = 32'd0;
				default: range_pick = $urandom_range(1, 100000);
			endcase
			cfg_write(CFG_RANGE, {$urandom, range_pick});
			if ($urandom_range(0, 1) == 1) begin
				cfg_write(CFG_SEED, {$urandom, $urandom});
			end
			if ($urandom_range(0, 7) == 0) begin
				cfg_write(CFG_IDX_W'($urandom_range(2, 255)), {$urandom, $urandom});
			end
			queue_draws($urandom_range(20, 70), 10, $urandom_range(0, 3) == 0);
			queue_draws($urandom_range(20, 70), 10, $urandom_range(0, 3) == 0);
			wait_drained();
		end

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#(64'd6_000_000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
